### src/object_header_parser_defines.svh
// Assertion macros shared by the object header parser checker.
// Depends on nothing; the including scope provides clk_i and rst_ni.
`ifndef OBJECT_HEADER_PARSER_DEFINES_SVH
`define OBJECT_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define OHP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define OHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ohp_pkg.sv
// Shared types, range code constants and the range length lookup
// for the object header parser. No dependencies.
package ohp_pkg;

  // Range codes with start/stop indices run from zero up to this code.
  localparam logic [3:0] RangeStartStopLast = 4'd2;
  // Reserved range codes: this single code, and everything from the next one up.
  localparam logic [3:0] RangeReservedA     = 4'd10;
  localparam logic [3:0] RangeReservedFrom  = 4'd12;
  localparam logic [3:0] FixedHeaderBytes   = 4'd3;

  typedef struct packed {
    logic [7:0]  group_code;
    logic [7:0]  variation_code;
    logic [3:0]  index_prefix;
    logic [3:0]  qual_range;
    logic [31:0] range_first;
    logic [31:0] range_last;
    logic [32:0] point_count;
    logic [3:0]  header_length;
    logic        bad_range_code;
  } ohp_result_t;

  // Number of range bytes that follow the qualifier for a given range code.
  function automatic logic [3:0] ohp_range_len(input logic [3:0] code);
    logic [3:0] len;
    unique case (code)
      4'd0:    len = 4'd2;
      4'd1:    len = 4'd4;
      4'd2:    len = 4'd8;
      4'd3:    len = 4'd1;
      4'd4:    len = 4'd2;
      4'd5:    len = 4'd4;
      4'd7:    len = 4'd1;
      4'd8:    len = 4'd2;
      4'd9:    len = 4'd4;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

endpackage

### src/ohp_decode.sv
// Decodes a fully captured object header into one result transaction.
// Depends on ohp_pkg.
module ohp_decode (
  input  logic [7:0]          group_i,
  input  logic [7:0]          variation_i,
  input  logic [7:0]          qualifier_i,
  input  logic [31:0]         first_i,
  input  logic [31:0]         last_i,
  output ohp_pkg::ohp_result_t result_o
);

  logic [3:0]  code;
  logic [3:0]  len;
  logic        is_start_stop;
  logic [31:0] span;

  assign code          = qualifier_i[3:0];
  assign len           = ohp_pkg::ohp_range_len(code);
  assign is_start_stop = (code <= ohp_pkg::RangeStartStopLast);
  assign span          = last_i - first_i;

  always_comb begin
    result_o.group_code     = group_i;
    result_o.variation_code = variation_i;
    result_o.index_prefix   = qualifier_i[7:4];
    result_o.qual_range     = code;
    result_o.header_length  = ohp_pkg::FixedHeaderBytes + len;
    result_o.bad_range_code = (code == ohp_pkg::RangeReservedA) ||
                              (code >= ohp_pkg::RangeReservedFrom);
    result_o.range_first    = '0;
    result_o.range_last     = '0;
    result_o.point_count    = '0;
    if (is_start_stop) begin
      result_o.range_first = first_i;
      result_o.range_last  = last_i;
      result_o.point_count = {1'b0, span} + 33'd1;
    end else if (len != 4'd0) begin
      result_o.point_count = {1'b0, first_i};
    end
  end

endmodule

### src/object_header_parser.sv
// Object header parser: one header byte per cycle unless stalled, one result per header.
// The result is registered and appears on the output in the cycle after the header's last byte.
// Throughput: one byte accepted every cycle; input stalls only while a result
// waits under out_stall_i. Reset (async, active low) returns to waiting for a group byte.
// Depends on ohp_pkg and ohp_decode.
module object_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        header_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  group_code_o,
  output logic [7:0]  variation_code_o,
  output logic [3:0]  index_prefix_o,
  output logic [3:0]  qual_range_o,
  output logic [31:0] range_first_o,
  output logic [31:0] range_last_o,
  output logic [32:0] point_count_o,
  output logic [3:0]  header_length_o,
  output logic        bad_range_code_o
);

  typedef enum logic [2:0] {
    PhGroup = 3'd0,
    PhVar   = 3'd1,
    PhQual  = 3'd2,
    PhRange = 3'd3
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  left_q, left_d;
  logic [3:0]  pos_q, pos_d;
  logic [7:0]  group_q, group_d;
  logic [7:0]  var_q, var_d;
  logic [7:0]  qual_q, qual_d;
  logic [31:0] first_q, first_d;
  logic [31:0] last_q, last_d;
  logic        out_valid_q, out_valid_d;
  logic        in_accept;
  logic        emit;
  logic [3:0]  held_code;
  logic [3:0]  half;
  logic [2:0]  pos3;
  logic [1:0]  last_sel;
  logic [31:0] byte_first;
  logic [31:0] byte_last;
  ohp_pkg::ohp_result_t result_d, result_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign held_code  = qual_q[3:0];
  assign half       = ohp_pkg::ohp_range_len(held_code) >> 1;
  assign pos3       = pos_q[2:0];
  assign last_sel   = pos3[1:0] - half[1:0];
  assign byte_first = {24'd0, data_byte_i} << {pos3[1:0], 3'b000};
  assign byte_last  = {24'd0, data_byte_i} << {last_sel, 3'b000};

  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    pos_d    = pos_q;
    group_d  = group_q;
    var_d    = var_q;
    qual_d   = qual_q;
    first_d  = first_q;
    last_d   = last_q;
    emit     = 1'b0;
    if (in_accept) begin
      if (header_start_i) begin
        // a group byte always restarts; drop any partial header
        group_d = data_byte_i;
        var_d   = '0;
        qual_d  = '0;
        first_d = '0;
        last_d  = '0;
        left_d  = '0;
        pos_d   = '0;
        phase_d = PhVar;
      end else begin
        unique case (phase_q)
          PhGroup: ; // stray byte, ignore
          PhVar: begin
            var_d   = data_byte_i;
            phase_d = PhQual;
          end
          PhQual: begin
            qual_d  = data_byte_i;
            first_d = '0;
            last_d  = '0;
            pos_d   = '0;
            if (ohp_pkg::ohp_range_len(data_byte_i[3:0]) == 4'd0) begin
              emit    = 1'b1;
              left_d  = '0;
              phase_d = PhGroup;
            end else begin
              left_d  = ohp_pkg::ohp_range_len(data_byte_i[3:0]);
              phase_d = PhRange;
            end
          end
          PhRange: begin
            if (held_code <= ohp_pkg::RangeStartStopLast && {1'b0, pos3} >= half) begin
              last_d = last_q | byte_last;
            end else begin
              first_d = first_q | byte_first;
            end
            pos_d = pos_q + 4'd1;
            if (left_q <= 4'd1) begin
              emit    = 1'b1;
              left_d  = '0;
              pos_d   = '0;
              phase_d = PhGroup;
            end else begin
              left_d = left_q - 4'd1;
            end
          end
          default: phase_d = PhGroup;
        endcase
      end
    end
    out_valid_d = emit || (out_valid_q && out_stall_i);
  end

  ohp_decode u_decode (
    .group_i     (group_d),
    .variation_i (var_d),
    .qualifier_i (qual_d),
    .first_i     (first_d),
    .last_i      (last_d),
    .result_o    (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhGroup;
      left_q      <= '0;
      pos_q       <= '0;
      group_q     <= '0;
      var_q       <= '0;
      qual_q      <= '0;
      first_q     <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
      result_q    <= '0;
    end else begin
      phase_q     <= phase_d;
      left_q      <= left_d;
      pos_q       <= pos_d;
      group_q     <= group_d;
      var_q       <= var_d;
      qual_q      <= qual_d;
      first_q     <= first_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      // hold the result until the downstream side takes it
      if (emit) begin
        result_q <= result_d;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign group_code_o     = result_q.group_code;
  assign variation_code_o = result_q.variation_code;
  assign index_prefix_o   = result_q.index_prefix;
  assign qual_range_o     = result_q.qual_range;
  assign range_first_o    = result_q.range_first;
  assign range_last_o     = result_q.range_last;
  assign point_count_o    = result_q.point_count;
  assign header_length_o  = result_q.header_length;
  assign bad_range_code_o = result_q.bad_range_code;

endmodule

### src/ohp_checker.sv
// Port-level checks for object_header_parser, attached by bind.
// Depends on ohp_pkg and object_header_parser_defines.svh.
`include "object_header_parser_defines.svh"

module ohp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        header_start_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  group_code_o,
  input logic [3:0]  qual_range_o,
  input logic [31:0] range_first_o,
  input logic [31:0] range_last_o,
  input logic [32:0] point_count_o,
  input logic [3:0]  header_length_o,
  input logic        bad_range_code_o
);

  `OHP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(point_count_o) && $stable(group_code_o), "stalled result changed")
  `OHP_ASSERT_NEXT(a_start_no_result, in_valid_i && !in_stall_o && header_start_i,
    !out_valid_o, "group byte produced a result")
  `OHP_ASSERT_NOW(a_bad_code_empty, out_valid_o && bad_range_code_o,
    header_length_o == ohp_pkg::FixedHeaderBytes && point_count_o == 33'd0,
    "reserved code with range data")
  `OHP_ASSERT_NOW(a_count_span, out_valid_o && qual_range_o <= ohp_pkg::RangeStartStopLast,
    point_count_o == {1'b0, 32'(range_last_o - range_first_o)} + 33'd1,
    "point count mismatch")
  `OHP_ASSERT_NOW(a_no_bounds, out_valid_o && qual_range_o > ohp_pkg::RangeStartStopLast,
    range_first_o == 32'd0 && range_last_o == 32'd0, "bounds set for count code")

endmodule

bind object_header_parser ohp_checker u_ohp_checker (.*);
